// ===== hw/rtl/thc_pkg.sv =====
// shared types, codes and constants of the tank pump hysteresis controller
`default_nettype none

package thc_pkg;

   // field widths
   localparam int LEVEL_W  = 10;
   localparam int PCT_W    = 7;
   localparam int THRESH_W = 11;
   localparam int TIME_W   = 32;
   localparam int TOTAL_W  = 32;

   // percent to tenths of a percent
   localparam int TENTHS_PER_PCT = 10;

   // divide by 1000 as (x * ceil(2^38 / 1000)) >> 38, exact for any 32-bit x
   localparam int             DIV_SHIFT = 38;
   localparam int             MAGIC_W   = 29;
   localparam logic [28:0]    DIV_MAGIC = 29'd274877907;
   localparam int             PROD_W    = TIME_W + MAGIC_W;
   localparam int             QUOT_W    = 23;

   // register reset values
   localparam logic [6:0]  START_LEVEL_RST = 7'd30;
   localparam logic [6:0]  STOP_LEVEL_RST  = 7'd90;
   localparam logic [31:0] OVERTIME_RST    = 32'd1800000;

   typedef enum logic [3:0] {
      RSN_HOLD         = 4'd0,
      RSN_FORCE        = 4'd1,
      RSN_FORCE_STOP   = 4'd2,
      RSN_AUTO_START   = 4'd3,
      RSN_AUTO_STOP    = 4'd4,
      RSN_SENSOR_FAULT = 4'd5,
      RSN_MANUAL_FORCE = 4'd6,
      RSN_MANUAL_OFF   = 4'd7,
      RSN_OVERTIME     = 4'd8
   } reason_type;

   typedef enum logic [1:0] {
      ST_NORMAL       = 2'd0,
      ST_RUNNING      = 2'd1,
      ST_SENSOR_FAULT = 2'd2,
      ST_CRITICAL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_START_LEVEL    = 2'd0,
      CSR_STOP_LEVEL     = 2'd1,
      CSR_OVERTIME_LIMIT = 2'd2,
      CSR_SENSOR_PRESENT = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [PCT_W-1:0]  start_level;
      logic [PCT_W-1:0]  stop_level;
      logic [TIME_W-1:0] overtime_limit_ms;
      logic              sensor_present;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [LEVEL_W-1:0] level_tenths;
      logic               sensor_good;
      logic               auto_mode;
      logic               force_set;
      logic               force_clear;
   } item_type;

   // decision stage result
   typedef struct packed {
      logic              pump_on;
      logic              pump_changed;
      reason_type        reason;
      status_type        status;
      logic              force_active;
      logic              stop;
      logic [TIME_W-1:0] elapsed_ms;
   } dec_type;

   // divide stage result
   typedef struct packed {
      logic              pump_on;
      logic              pump_changed;
      reason_type        reason;
      status_type        status;
      logic              force_active;
      logic [QUOT_W-1:0] run_seconds;
   } div_type;

endpackage

`default_nettype wire

// ===== hw/rtl/thc_decide.sv =====
// pump decision logic with the controller state and the decision stage register
`default_nettype none

module thc_decide (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             ld,
   input  wire thc_pkg::item_type item,
   input  wire thc_pkg::cfg_type  cfg,
   output thc_pkg::dec_type       dec
);
   import thc_pkg::*;

   logic                running_ff, running_in;
   logic [TIME_W-1:0]   run_start_ff, run_start_in;
   logic                force_ff, force_in;
   status_type          status_ff, status_in;
   dec_type             dec_ff, dec_in;

   logic                healthy;
   logic [THRESH_W-1:0] start_t;
   logic [THRESH_W-1:0] stop_t;
   logic [THRESH_W-1:0] level;
   logic [TIME_W-1:0]   elapsed;
   logic                force_pre;
   logic                want;
   logic                tripped;
   logic                changed;
   reason_type          reason;

   // thresholds and run length
   always_comb begin
      healthy = item.sensor_good | ~cfg.sensor_present;
      start_t = THRESH_W'(cfg.start_level) * THRESH_W'(TENTHS_PER_PCT);
      stop_t  = THRESH_W'(cfg.stop_level) * THRESH_W'(TENTHS_PER_PCT);
      level   = THRESH_W'(item.level_tenths);
      elapsed = item.now_ms - run_start_ff;
   end

   // force request, mode decision, overtime cutoff and state update
   always_comb begin
      running_in   = running_ff;
      run_start_in = run_start_ff;
      status_in    = status_ff;
      want         = 1'b0;
      reason       = RSN_HOLD;
      tripped      = 1'b0;

      priority if (item.force_clear) begin
         force_pre = 1'b0;
      end else if (item.force_set) begin
         force_pre = 1'b1;
      end else begin
         force_pre = force_ff;
      end
      force_in = force_pre;

      if (item.auto_mode) begin
         if (healthy) begin
            priority if (force_pre) begin
               if (level >= stop_t) begin
                  want     = 1'b0;
                  reason   = RSN_FORCE_STOP;
                  force_in = 1'b0;
               end else begin
                  want   = 1'b1;
                  reason = RSN_FORCE;
               end
            end else if (!running_ff && level < start_t) begin
               want   = 1'b1;
               reason = RSN_AUTO_START;
            end else if (running_ff && level >= stop_t) begin
               want   = 1'b0;
               reason = RSN_AUTO_STOP;
            end else begin
               want = running_ff;
            end
         end else begin
            want   = 1'b0;
            reason = RSN_SENSOR_FAULT;
         end
      end else begin
         want   = force_pre;
         reason = force_pre ? RSN_MANUAL_FORCE : RSN_MANUAL_OFF;
      end

      // safety cutoff on a run that is too long
      if (want && running_ff && elapsed > cfg.overtime_limit_ms) begin
         want      = 1'b0;
         reason    = RSN_OVERTIME;
         tripped   = 1'b1;
         force_in  = 1'b0;
         status_in = ST_CRITICAL;
      end

      changed    = want != running_ff;
      running_in = want;
      if (changed) begin
         if (want) begin
            status_in    = ST_RUNNING;
            run_start_in = item.now_ms;
         end else if (!tripped) begin
            status_in = healthy ? ST_NORMAL : ST_SENSOR_FAULT;
         end
      end

      dec_in.pump_on      = want;
      dec_in.pump_changed = changed;
      dec_in.reason       = reason;
      dec_in.status       = status_in;
      dec_in.force_active = force_in;
      dec_in.stop         = changed & ~want;
      dec_in.elapsed_ms   = elapsed;
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         run_start_ff <= '0;
         force_ff     <= 1'b0;
         status_ff    <= ST_NORMAL;
      end else if (ld) begin
         running_ff   <= running_in;
         run_start_ff <= run_start_in;
         force_ff     <= force_in;
         status_ff    <= status_in;
      end
   end

   // decision stage register
   always_ff @(posedge clock) begin
      if (ld) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/thc_div.sv =====
// run length in ms to whole seconds by reciprocal multiplication
`default_nettype none

module thc_div (
   input  wire logic             clock,
   input  wire logic             ld,
   input  wire thc_pkg::dec_type dec,
   output thc_pkg::div_type      div
);
   import thc_pkg::*;

   div_type           div_ff, div_in;
   logic [PROD_W-1:0] prod;

   // quotient is only added to the total on a stop
   always_comb begin
      prod                = PROD_W'(dec.elapsed_ms) * PROD_W'(DIV_MAGIC);
      div_in.pump_on      = dec.pump_on;
      div_in.pump_changed = dec.pump_changed;
      div_in.reason       = dec.reason;
      div_in.status       = dec.status;
      div_in.force_active = dec.force_active;
      div_in.run_seconds  = dec.stop ? prod[DIV_SHIFT +: QUOT_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         div_ff <= div_in;
      end
   end

   assign div = div_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/thc_accum.sv =====
// run seconds total and the result register
`default_nettype none

module thc_accum (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             ld,
   input  wire thc_pkg::div_type div,
   output thc_pkg::div_type      rsp,
   output logic [thc_pkg::TOTAL_W-1:0] total
);
   import thc_pkg::*;

   logic [TOTAL_W-1:0] total_ff, total_in;
   div_type            rsp_ff;

   // total wraps modulo 2^32
   assign total_in = total_ff + TOTAL_W'(div.run_seconds);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (ld) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         rsp_ff <= div;
      end
   end

   assign rsp   = rsp_ff;
   assign total = total_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tank_pump_hysteresis_controller.sv =====
// Tank pump hysteresis controller top level.
// Each request is one evaluation: time stamp, level in tenths of a percent,
// sensor health, mode and force set/clear. Each request yields exactly one
// response: pump state, toggle flag, reason code, status, run seconds total
// and force flag, in request order.
// Request and response channels use valid/stall; a transfer happens on a
// rising edge with valid high and stall low. Registers are written through
// the csr channel (index 0 start level, 1 stop level, 2 overtime limit,
// 3 sensor present); csr_ready is always high.
// Pipeline: input register, decision stage (holds the pump state), divide
// stage (run ms to seconds by one 32x29 multiply), result register with the
// seconds total. A request passes the decision, divide and result registers
// in turn. With rsp_stall low, one request per cycle is sustained, set by
// the decision stage, whose state feeds the next request directly.
// When rsp_stall is high, the result holds and the stages behind it fill;
// req_stall rises once all four stages are full.
// Synchronous reset: pump off, force clear, status normal, total zero,
// registers to their defaults, pipeline empty.
`default_nettype none

module tank_pump_hysteresis_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [9:0]  req_level_tenths,
   input  wire logic        req_sensor_good,
   input  wire logic        req_auto_mode,
   input  wire logic        req_force_set,
   input  wire logic        req_force_clear,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_pump_on,
   output logic             rsp_pump_changed,
   output logic [3:0]       rsp_reason_code,
   output logic [1:0]       rsp_system_status,
   output logic [31:0]      rsp_total_run_seconds,
   output logic             rsp_force_active,
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import thc_pkg::*;

   cfg_type  cfg_ff;
   item_type item_ff;
   dec_type  dec;
   div_type  div;
   div_type  rsp;

   logic v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in, vo_ff, vo_in;
   logic rdy0, rdy1, rdy2, rdyo;
   logic ld1, ld2, ldo, accept;

   // pipeline flow control
   always_comb begin
      rdyo   = ~vo_ff | ~rsp_stall;
      ldo    = v2_ff & rdyo;
      rdy2   = ~v2_ff | rdyo;
      ld2    = v1_ff & rdy2;
      rdy1   = ~v1_ff | rdy2;
      ld1    = v0_ff & rdy1;
      rdy0   = ~v0_ff | rdy1;
      accept = req_valid & rdy0;
      v0_in  = accept | (v0_ff & ~ld1);
      v1_in  = ld1 | (v1_ff & ~ld2);
      v2_in  = ld2 | (v2_ff & ~ldo);
      vo_in  = ldo | (vo_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         vo_ff <= vo_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.now_ms       <= req_now_ms;
         item_ff.level_tenths <= req_level_tenths;
         item_ff.sensor_good  <= req_sensor_good;
         item_ff.auto_mode    <= req_auto_mode;
         item_ff.force_set    <= req_force_set;
         item_ff.force_clear  <= req_force_clear;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level       <= START_LEVEL_RST;
         cfg_ff.stop_level        <= STOP_LEVEL_RST;
         cfg_ff.overtime_limit_ms <= OVERTIME_RST;
         cfg_ff.sensor_present    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_LEVEL:    cfg_ff.start_level       <= csr_data[PCT_W-1:0];
            CSR_STOP_LEVEL:     cfg_ff.stop_level        <= csr_data[PCT_W-1:0];
            CSR_OVERTIME_LIMIT: cfg_ff.overtime_limit_ms <= csr_data;
            CSR_SENSOR_PRESENT: cfg_ff.sensor_present    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   thc_decide u_decide (
      .clock (clock),
      .reset (reset),
      .ld    (ld1),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .dec   (dec)
   );

   thc_div u_div (
      .clock (clock),
      .ld    (ld2),
      .dec   (dec),
      .div   (div)
   );

   thc_accum u_accum (
      .clock (clock),
      .reset (reset),
      .ld    (ldo),
      .div   (div),
      .rsp   (rsp),
      .total (rsp_total_run_seconds)
   );

   // response and request ports
   assign req_stall         = ~rdy0;
   assign rsp_valid         = vo_ff;
   assign rsp_pump_on       = rsp.pump_on;
   assign rsp_pump_changed  = rsp.pump_changed;
   assign rsp_reason_code   = rsp.reason;
   assign rsp_system_status = rsp.status;
   assign rsp_force_active  = rsp.force_active;

endmodule

`default_nettype wire

// ===== hw/rtl/thc_checker.sv =====
// port-level checks of the tank pump hysteresis controller and their bind
`default_nettype none

module thc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_pump_on,
   input wire logic        rsp_pump_changed,
   input wire logic [3:0]  rsp_reason_code,
   input wire logic [1:0]  rsp_system_status,
   input wire logic [31:0] rsp_total_run_seconds,
   input wire logic        rsp_force_active
);
   import thc_pkg::*;

   // a pump start always reports running status
   a_start_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pump_changed && rsp_pump_on |-> rsp_system_status == ST_RUNNING)
      else $error("pump start without running status");

   // overtime cuts the pump, drops force and latches critical status
   a_overtime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reason_code == RSN_OVERTIME |->
         !rsp_pump_on && rsp_pump_changed && !rsp_force_active
         && rsp_system_status == ST_CRITICAL)
      else $error("overtime response inconsistent");

   // an auto start always turns the pump on
   a_auto_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reason_code == RSN_AUTO_START |-> rsp_pump_on && rsp_pump_changed)
      else $error("auto start without pump toggle on");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_run_seconds)
         && $stable(rsp_reason_code) && $stable(rsp_system_status))
      else $error("stalled response changed");

endmodule

bind tank_pump_hysteresis_controller thc_checker u_thc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_pump_on           (rsp_pump_on),
   .rsp_pump_changed      (rsp_pump_changed),
   .rsp_reason_code       (rsp_reason_code),
   .rsp_system_status     (rsp_system_status),
   .rsp_total_run_seconds (rsp_total_run_seconds),
   .rsp_force_active      (rsp_force_active)
);

`default_nettype wire
